FILE: hdl/gws_pkg.sv
// ----------------------------------------------------------------------------
// gws_pkg
// Shared types, constants and register indexes of the Gaussian wavelet
// spectrum weighting core.
// ----------------------------------------------------------------------------
package gws_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TERMS    = 12;

    localparam logic [2:0] REG_SCALE_OFS   = 3'd0;
    localparam logic [2:0] REG_OCTAVE_STEP = 3'd1;
    localparam logic [2:0] REG_SIGMA_WIDTH = 3'd2;
    localparam logic [2:0] REG_NORM_GAIN   = 3'd3;
    localparam logic [2:0] REG_HALF_COUNT  = 3'd4;
    localparam logic [2:0] REG_LOG2_BINS   = 3'd5;
    localparam logic [2:0] REG_NUM_SCALES  = 3'd6;

    localparam logic [30:0] ONE_Q30        = 31'd1073741824;
    localparam logic [29:0] LN2_Q30        = 30'd744261118;
    localparam logic [30:0] TWO_PI_Q28     = 31'd1686629713;
    localparam logic [31:0] FOUR_PI_Q28    = 32'd3373259426;
    localparam logic [44:0] PI_Q24         = 45'd52707179;
    localparam logic [30:0] SQRT_LOG2E_Q30 = 31'd1289695365;
    localparam logic [44:0] X_CAP          = 45'h100000000000;

    // floor(2^32 / k) for the series divisors
    localparam logic [32:0] RECIP [1:TERMS] = '{
        33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,  33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,  33'd429496729,  33'd390451572,  33'd357913941
    };

    typedef struct packed {
        logic signed [15:0] fsv;
        logic [16:0]        octave;
        logic [4:0]         lbins;
        logic [8:0]         nscale;
        logic [24:0]        sg;
        logic [43:0]        gain;
        logic               busy;
    } cfg_t;

    typedef struct packed {
        logic [7:0]                 row;
        logic [15:0]                bin;
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       inv;
        logic                       zero;
        logic signed [12:0]         ip;
        logic [7:0]                 wn;
        logic                       rz;
        logic                       wz;
    } item_t;

    typedef struct packed {
        logic [15:0]         bin;
        logic [7:0]          row;
        logic [SAMPLE_W-1:0] im;
        logic [SAMPLE_W-1:0] re;
        logic                inv;
        logic                sat;
    } res_t;

endpackage

FILE: hdl/gws_cfg.sv
// ----------------------------------------------------------------------------
// gws_cfg
// Configuration registers and the sequencer that derives the sigma factor
// and the overall gain (square root and long division, one bit a cycle).
// ----------------------------------------------------------------------------
module gws_cfg
    import gws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [23:0] wr_data,
    output cfg_t        cfg
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_GAIN = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;

    logic [15:0] fs_reg;
    logic [16:0] oct_reg;
    logic [23:0] sig_reg;
    logic [23:0] norm_reg;
    logic [15:0] half_reg;
    logic [4:0]  lb_reg;
    logic [8:0]  ns_reg;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [27:0] v_reg;
    logic [24:0] sg_reg;
    logic [21:0] root_reg;
    logic [4:0]  bit_reg;
    logic [44:0] num_reg;
    logic [31:0] rem_reg;
    logic [44:0] quo_reg;
    logic [31:0] div_reg;
    logic [5:0]  cnt_reg;

    logic [4:0]  lc;
    logic [8:0]  nc;
    logic [15:0] hc;
    logic [55:0] prod_v;
    logic [54:0] prod_s;
    logic [21:0] trial;
    logic [43:0] sq;
    logic [45:0] prod_g;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg   <= 16'd0;
            oct_reg  <= 17'd16384;
            sig_reg  <= 24'd65536;
            norm_reg <= 24'd65536;
            half_reg <= 16'd1;
            lb_reg   <= 5'd10;
            ns_reg   <= 9'd1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SCALE_OFS:   fs_reg   <= wr_data[15:0];
                REG_OCTAVE_STEP: oct_reg  <= wr_data[16:0];
                REG_SIGMA_WIDTH: sig_reg  <= wr_data;
                REG_NORM_GAIN:   norm_reg <= wr_data;
                REG_HALF_COUNT:  half_reg <= wr_data[15:0];
                REG_LOG2_BINS:   lb_reg   <= wr_data[4:0];
                REG_NUM_SCALES:  ns_reg   <= wr_data[8:0];
                default:         ;
            endcase
        end
    end

    assign lc = (lb_reg == 5'd0) ? 5'd1 : ((lb_reg > 5'd16) ? 5'd16 : lb_reg);
    assign nc = (ns_reg == 9'd0) ? 9'd1 : ((ns_reg > 9'd256) ? 9'd256 : ns_reg);
    assign hc = (half_reg == 16'd0) ? 16'd1 : half_reg;

    assign prod_v  = sig_reg * FOUR_PI_Q28;
    assign prod_s  = sig_reg * SQRT_LOG2E_Q30;
    assign trial   = root_reg | (22'd1 << bit_reg);
    assign sq      = trial * trial;
    assign prod_g  = norm_reg * root_reg;
    assign rem_sh  = {rem_reg, num_reg[44]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign ge      = rem_sh >= {1'b0, div_reg};

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = ST_IDLE;
            ST_MUL:  state_next = ST_ROOT;
            ST_ROOT: state_next = (bit_reg == 5'd0) ? ST_GAIN : ST_ROOT;
            ST_GAIN: state_next = ST_DIV;
            ST_DIV:  state_next = (cnt_reg == 6'd0) ? ST_IDLE : ST_DIV;
            default: state_next = ST_IDLE;
        endcase
        if (wr_en)
        begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_MUL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MUL:
            begin
                v_reg    <= prod_v[55:28];
                sg_reg   <= prod_s[54:30];
                root_reg <= 22'd0;
                bit_reg  <= 5'd21;
            end
            ST_ROOT:
            begin
                if (sq <= {v_reg, 16'd0})
                begin
                    root_reg <= trial;
                end
                bit_reg <= bit_reg - 5'd1;
            end
            ST_GAIN:
            begin
                num_reg <= {prod_g[45:16], 15'd0};
                rem_reg <= 32'd0;
                cnt_reg <= 6'd44;
                div_reg <= {16'd0, hc} << lc;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? rem_sub[31:0] : rem_sh[31:0];
                num_reg <= num_reg << 1;
                quo_reg <= {quo_reg[43:0], ge};
                cnt_reg <= cnt_reg - 6'd1;
            end
            default: ;
        endcase
    end

    assign cfg.fsv    = $signed(fs_reg);
    assign cfg.octave = oct_reg;
    assign cfg.lbins  = lc;
    assign cfg.nscale = nc;
    assign cfg.sg     = sg_reg;
    assign cfg.gain   = quo_reg[43:0];
    assign cfg.busy   = state_reg != ST_IDLE;

endmodule

FILE: hdl/gws_front.sv
// ----------------------------------------------------------------------------
// gws_front
// Input stage: scale exponent, row index and the invalid and upper-half
// flags of each item.
// ----------------------------------------------------------------------------
module gws_front
    import gws_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [7:0]          scale,
    input  logic [15:0]         bin,
    input  logic [SAMPLE_W-1:0] re,
    input  logic [SAMPLE_W-1:0] im,
    input  cfg_t                cfg,
    output logic                out_valid,
    output item_t               out_item,
    output logic [23:0]         out_f
);

    logic signed [17:0] t;
    logic signed [35:0] prod;
    logic [36:0]        tt;
    item_t              item;

    assign t    = $signed({2'b00, scale, 8'h00}) + $signed({{2{cfg.fsv[15]}}, cfg.fsv});
    assign prod = $signed({1'b0, cfg.octave}) * t;
    assign tt   = {prod[35], prod} - {8'd0, cfg.lbins, 24'd0};

    always_comb
    begin
        item      = '0;
        item.row  = 8'(cfg.nscale - 9'd1 - {1'b0, scale});
        item.bin  = bin;
        item.re   = $signed(re);
        item.im   = $signed(im);
        item.inv  = cfg.fsv < -16'sd128;
        item.zero = (bin >> (cfg.lbins - 5'd1)) != 16'd0;
        item.ip   = $signed(tt[36:24]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item <= item;
            out_f    <= tt[23:0];
        end
    end

endmodule

FILE: hdl/gws_exp2.sv
// ----------------------------------------------------------------------------
// gws_exp2
// Pipelined 2^f for a Q24 fraction, Q30 result: twelve series terms, each
// a multiply, a reciprocal divide and a correction stage.
// ----------------------------------------------------------------------------
module gws_exp2
    import gws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [23:0] in_f,
    output logic        out_valid,
    output item_t       out_item,
    output logic [31:0] out_sum
);

    logic        v_reg  [0:TERMS];
    item_t       it_reg [0:TERMS];
    logic [29:0] y_reg  [0:TERMS];
    logic [30:0] t_reg  [0:TERMS];
    logic [31:0] s_reg  [0:TERMS];
    logic [53:0] y_prod;

    assign y_prod = in_f * LN2_Q30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0] <= in_item;
            y_reg[0]  <= y_prod[53:24];
            t_reg[0]  <= ONE_Q30;
            s_reg[0]  <= {1'b0, ONE_Q30};
        end
    end

    for (genvar k = 1; k <= TERMS; k++)
    begin : g_term
        logic        va_reg;
        logic        vb_reg;
        item_t       ita_reg;
        item_t       itb_reg;
        logic [29:0] ya_reg;
        logic [29:0] yb_reg;
        logic [29:0] pa_reg;
        logic [29:0] pb_reg;
        logic [29:0] qb_reg;
        logic [31:0] sa_reg;
        logic [31:0] sb_reg;
        logic [60:0] prod_a;
        logic [62:0] prod_b;
        logic [33:0] qk;
        logic [29:0] qfix;

        assign prod_a = t_reg[k-1] * y_reg[k-1];
        assign prod_b = pa_reg * RECIP[k];
        assign qk     = qb_reg * 4'(k);
        assign qfix   = (({4'd0, pb_reg} - qk) >= 34'(k)) ? qb_reg + 30'd1 : qb_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg   <= 1'b0;
                vb_reg   <= 1'b0;
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                va_reg   <= v_reg[k-1];
                vb_reg   <= va_reg;
                v_reg[k] <= vb_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ita_reg   <= it_reg[k-1];
                ya_reg    <= y_reg[k-1];
                sa_reg    <= s_reg[k-1];
                pa_reg    <= prod_a[59:30];
                itb_reg   <= ita_reg;
                yb_reg    <= ya_reg;
                sb_reg    <= sa_reg;
                pb_reg    <= pa_reg;
                qb_reg    <= prod_b[61:32];
                it_reg[k] <= itb_reg;
                y_reg[k]  <= yb_reg;
                t_reg[k]  <= {1'b0, qfix};
                s_reg[k]  <= sb_reg + {2'b00, qfix};
            end
        end
    end

    assign out_valid = v_reg[TERMS];
    assign out_item  = it_reg[TERMS];
    assign out_sum   = s_reg[TERMS];

endmodule

FILE: hdl/gws_window.sv
// ----------------------------------------------------------------------------
// gws_window
// Bin position x, its distance from pi, the Gaussian argument q and the
// exponent q^2 that feeds the second 2^f unit.
// ----------------------------------------------------------------------------
module gws_window
    import gws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [31:0] in_sum,
    input  cfg_t        cfg,
    output logic        out_valid,
    output item_t       out_item,
    output logic [23:0] out_f
);

    logic [6:1]  v_reg;
    item_t       w1_item_reg;
    item_t       w2_item_reg;
    item_t       w3_item_reg;
    item_t       w4_item_reg;
    item_t       w5_item_reg;
    logic [33:0] p2_reg;
    logic [49:0] xv_reg;
    logic [44:0] x_reg;
    logic [36:0] dd_reg;
    logic [45:0] q_reg;

    logic [62:0] prod_p2;
    logic [49:0] prod_xv;
    logic [13:0] sh;
    logic [13:0] rs;
    logic [49:0] xw;
    logic [44:0] diff;
    logic [61:0] prod_q;
    logic [39:0] qsq;
    item_t       w6_item;

    assign prod_p2 = in_sum * TWO_PI_Q28;
    assign prod_xv = w1_item_reg.bin * p2_reg;

    always_comb
    begin
        sh = {w2_item_reg.ip[12], w2_item_reg.ip} - 14'd6;
        rs = 14'd0 - sh;
        xw = 50'd0;
        if (xv_reg == 50'd0)
        begin
            xw = 50'd0;
        end
        else if (sh[13])
        begin
            xw = (rs >= 14'd50) ? 50'd0 : (xv_reg >> rs[5:0]);
        end
        else if (sh > 14'd44)
        begin
            xw = {5'd0, X_CAP};
        end
        else if (xv_reg > ({5'd0, X_CAP} >> sh[5:0]))
        begin
            xw = {5'd0, X_CAP};
        end
        else
        begin
            xw = xv_reg << sh[5:0];
        end
        if (xw > {5'd0, X_CAP})
        begin
            xw = {5'd0, X_CAP};
        end
    end

    assign diff   = (x_reg >= PI_Q24) ? x_reg - PI_Q24 : PI_Q24 - x_reg;
    assign prod_q = dd_reg * cfg.sg;
    assign qsq    = q_reg[19:0] * q_reg[19:0];

    always_comb
    begin
        w6_item    = w5_item_reg;
        w6_item.wz = q_reg[45:20] != 26'd0;
        w6_item.wn = qsq[39:32];
        w6_item.rz = qsq[31:8] == 24'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_item_reg <= in_item;
            p2_reg      <= prod_p2[61:28];
            w2_item_reg <= w1_item_reg;
            xv_reg      <= prod_xv;
            w3_item_reg <= w2_item_reg;
            x_reg       <= xw[44:0];
            w4_item_reg <= w3_item_reg;
            dd_reg      <= diff[44:8];
            w5_item_reg <= w4_item_reg;
            q_reg       <= prod_q[61:16];
            out_item    <= w6_item;
            out_f       <= 24'd0 - qsq[31:8];
        end
    end

    assign out_valid = v_reg[6];

endmodule

FILE: hdl/gws_apply.sv
// ----------------------------------------------------------------------------
// gws_apply
// Weight from 2^(-s), gain product, bin-0 halving, the complex scaling with
// rounding and saturation, and the invalid and upper-half zeroing.
// ----------------------------------------------------------------------------
module gws_apply
    import gws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [31:0] in_sum,
    input  cfg_t        cfg,
    output logic        out_valid,
    output res_t        out_res
);

    logic [5:1]  v_reg;
    item_t       a1_item_reg;
    item_t       a2_item_reg;
    item_t       a3_item_reg;
    item_t       a4_item_reg;
    logic [30:0] wt_reg;
    logic [59:0] hi_reg;
    logic [45:0] lo_reg;
    logic [43:0] f_reg;
    logic [15:0] mre_reg;
    logic [15:0] mim_reg;
    logic [37:0] phr_reg;
    logic [37:0] plr_reg;
    logic [37:0] phi_reg;
    logic [37:0] pli_reg;

    logic [30:0] wt;
    logic [31:0] sum_sh;
    logic [60:0] acc;
    logic [43:0] fv;
    logic [60:0] full_re;
    logic [60:0] full_im;
    logic [30:0] r_re;
    logic [30:0] r_im;
    logic [16:0] lim_re;
    logic [16:0] lim_im;
    logic        sat_re;
    logic        sat_im;
    logic [15:0] v_re;
    logic [15:0] v_im;
    res_t        res;

    assign sum_sh = in_sum >> ({1'b0, in_item.wn[4:0]} + 6'd1);

    always_comb
    begin
        if (in_item.wz || (in_item.wn >= 8'd31))
        begin
            wt = 31'd0;
        end
        else if (in_item.rz)
        begin
            wt = ONE_Q30 >> in_item.wn[4:0];
        end
        else
        begin
            wt = sum_sh[30:0];
        end
    end

    assign acc = {1'b0, hi_reg} + {30'd0, lo_reg[45:15]};
    assign fv  = (a2_item_reg.bin == 16'd0) ? {1'b0, acc[58:16]} : acc[58:15];

    assign full_re = {1'b0, phr_reg, 22'd0} + {23'd0, plr_reg} + 61'h20000000;
    assign full_im = {1'b0, phi_reg, 22'd0} + {23'd0, pli_reg} + 61'h20000000;
    assign r_re    = full_re[60:30];
    assign r_im    = full_im[60:30];
    assign lim_re  = a4_item_reg.re[SAMPLE_W-1] ? 17'd32768 : 17'd32767;
    assign lim_im  = a4_item_reg.im[SAMPLE_W-1] ? 17'd32768 : 17'd32767;
    assign sat_re  = r_re > {14'd0, lim_re};
    assign sat_im  = r_im > {14'd0, lim_im};

    always_comb
    begin
        v_re = sat_re ? lim_re[15:0] : r_re[15:0];
        v_im = sat_im ? lim_im[15:0] : r_im[15:0];
        if (a4_item_reg.re[SAMPLE_W-1])
        begin
            v_re = 16'd0 - v_re;
        end
        if (a4_item_reg.im[SAMPLE_W-1])
        begin
            v_im = 16'd0 - v_im;
        end
        res.bin = a4_item_reg.bin;
        res.row = a4_item_reg.row;
        res.inv = a4_item_reg.inv;
        res.re  = v_re;
        res.im  = v_im;
        res.sat = sat_re | sat_im;
        if (a4_item_reg.inv || a4_item_reg.zero)
        begin
            res.re  = '0;
            res.im  = '0;
            res.sat = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_item_reg <= in_item;
            wt_reg      <= wt;
            a2_item_reg <= a1_item_reg;
            hi_reg      <= cfg.gain[43:15] * wt_reg;
            lo_reg      <= cfg.gain[14:0] * wt_reg;
            a3_item_reg <= a2_item_reg;
            f_reg       <= fv;
            mre_reg     <= a2_item_reg.re[SAMPLE_W-1] ? 16'd0 - a2_item_reg.re : a2_item_reg.re;
            mim_reg     <= a2_item_reg.im[SAMPLE_W-1] ? 16'd0 - a2_item_reg.im : a2_item_reg.im;
            a4_item_reg <= a3_item_reg;
            phr_reg     <= mre_reg * f_reg[43:22];
            plr_reg     <= mre_reg * f_reg[21:0];
            phi_reg     <= mim_reg * f_reg[43:22];
            pli_reg     <= mim_reg * f_reg[21:0];
            out_res     <= res;
        end
    end

    assign out_valid = v_reg[5];

endmodule

FILE: hdl/gaussian_wavelet_spectrum_weight_core.sv
// ----------------------------------------------------------------------------
// gaussian_wavelet_spectrum_weight_core
// Weights one complex spectrum bin per item by a Gaussian window for its
// scale row, with rounding and saturation to Q1.15.
//
//  channel  | signals                               | width
//  ---------+---------------------------------------+---------------------
//  input    | s_tvalid s_tready s_tdata             | 56 data
//  output   | m_tvalid m_tready m_tdata m_tuser     | 56 data, 2 user
//  config   | wr_en wr_index wr_data                | 3 index, 24 data
//
// One item per cycle while s_tready is high; an item passes the front stage,
// the two 37-stage series pipelines, the window and the apply stages to the output queue.
// After reset and after every register write the gain sequencer runs its
// square root and long division, one bit a cycle; s_tready is low meanwhile.
// A two-item output queue parts the sides; the pipeline holds when it fills.
// ----------------------------------------------------------------------------
module gaussian_wavelet_spectrum_weight_core
    import gws_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // scale_index, bin_index, in_re, in_im
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_re, out_im, out_row, out_bin
    output logic [1:0]  m_tuser,   // invalid, saturated
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [23:0] wr_data
);

    cfg_t        cfg;
    logic        adv;
    logic        fr_valid;
    item_t       fr_item;
    logic [23:0] fr_f;
    logic        e1_valid;
    item_t       e1_item;
    logic [31:0] e1_sum;
    logic        wn_valid;
    item_t       wn_item;
    logic [23:0] wn_f;
    logic        e2_valid;
    item_t       e2_item;
    logic [31:0] e2_sum;
    logic        ap_valid;
    res_t        ap_res;

    res_t        fifo_mem [0:1];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;
    res_t        head;

    assign adv      = count_reg != 2'd2;
    assign s_tready = adv & ~cfg.busy;

    gws_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    gws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid & s_tready),
        .scale     (s_tdata[7:0]),
        .bin       (s_tdata[23:8]),
        .re        (s_tdata[39:24]),
        .im        (s_tdata[55:40]),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .out_item  (fr_item),
        .out_f     (fr_f)
    );

    gws_exp2 u_exp_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_item   (fr_item),
        .in_f      (fr_f),
        .out_valid (e1_valid),
        .out_item  (e1_item),
        .out_sum   (e1_sum)
    );

    gws_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e1_valid),
        .in_item   (e1_item),
        .in_sum    (e1_sum),
        .cfg       (cfg),
        .out_valid (wn_valid),
        .out_item  (wn_item),
        .out_f     (wn_f)
    );

    gws_exp2 u_exp_w (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (wn_valid),
        .in_item   (wn_item),
        .in_f      (wn_f),
        .out_valid (e2_valid),
        .out_item  (e2_item),
        .out_sum   (e2_sum)
    );

    gws_apply u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (e2_valid),
        .in_item   (e2_item),
        .in_sum    (e2_sum),
        .cfg       (cfg),
        .out_valid (ap_valid),
        .out_res   (ap_res)
    );

    assign push = ap_valid & adv;
    assign pop  = m_tvalid & m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= ap_res;
        end
    end

    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = count_reg != 2'd0;
    assign m_tdata  = {head.bin, head.row, head.im, head.re};
    assign m_tuser  = {head.sat, head.inv};

endmodule
